// ----- design/elx_pkg.sv -----
// Shared types and constants of the expression lexer.
`default_nettype none

package elx_pkg;

    // Default parameter values handed down from the top level.
    localparam int POSITION_WIDTH_DEF    = 16;
    localparam int KEYWORD_MAX_CHARS_DEF = 9;

    // Bundles of tokens that the queue between front and back can hold.
    localparam int QUEUE_DEPTH = 4;

    // Most tokens that one character item can cause.
    localparam int MAX_TOKENS = 3;

    // Token kinds.
    localparam logic [4:0] KIND_EOF      = 5'd0;
    localparam logic [4:0] KIND_PLUS     = 5'd1;
    localparam logic [4:0] KIND_MINUS    = 5'd2;
    localparam logic [4:0] KIND_STAR     = 5'd3;
    localparam logic [4:0] KIND_SLASH    = 5'd4;
    localparam logic [4:0] KIND_LPAREN   = 5'd5;
    localparam logic [4:0] KIND_RPAREN   = 5'd6;
    localparam logic [4:0] KIND_GT       = 5'd7;
    localparam logic [4:0] KIND_LT       = 5'd8;
    localparam logic [4:0] KIND_LE       = 5'd9;
    localparam logic [4:0] KIND_NUMBER   = 5'd13;
    localparam logic [4:0] KIND_IDENT    = 5'd14;
    localparam logic [4:0] KIND_KEYWORD0 = 5'd15;
    localparam logic [4:0] KIND_ERROR    = 5'd21;

    // Characters with a role of their own.
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Codes of the operator characters that wait for a following '='.
    localparam logic [1:0] PEND_LT   = 2'd0;
    localparam logic [1:0] PEND_GT   = 2'd1;
    localparam logic [1:0] PEND_EQ   = 2'd2;
    localparam logic [1:0] PEND_BANG = 2'd3;

    // Keywords, right-justified text, first character in the highest used byte.
    localparam int KW_COUNT     = 6;
    localparam int KW_TEXT_BITS = 72;
    localparam logic [KW_TEXT_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        KW_TEXT_BITS'("know"), KW_TEXT_BITS'("suppose"), KW_TEXT_BITS'("otherwise"),
        KW_TEXT_BITS'("end"), KW_TEXT_BITS'("doom"), KW_TEXT_BITS'("crime")
    };
    localparam int KW_LEN [KW_COUNT] = '{4, 7, 9, 3, 4, 5};

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
    } token_t;

    // Tokens caused by one item, in emission order from entry 0.
    typedef struct packed {
        logic [1:0]                  count;
        token_t [MAX_TOKENS-1:0]     tok;
    } bundle_t;

endpackage

`default_nettype wire

// ----- design/elx_front.sv -----
// Front part: takes characters, tracks the scan state and forms token bundles.
`default_nettype none

module elx_front #(
    parameter int POSITION_WIDTH    = elx_pkg::POSITION_WIDTH_DEF,
    parameter int KEYWORD_MAX_CHARS = elx_pkg::KEYWORD_MAX_CHARS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,
    input  wire logic             s_tuser,
    input  wire logic             s_tlast,
    output logic                  push,
    output elx_pkg::bundle_t      push_bundle,
    input  wire logic             queue_full
);

    localparam int PW = POSITION_WIDTH;
    localparam int KI = $clog2(KEYWORD_MAX_CHARS);

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_WORD    = 5'b00010,
        MODE_NUMBER  = 5'b00100,
        MODE_PENDING = 5'b01000,
        MODE_DISCARD = 5'b10000
    } mode_t;

    mode_t          mode_reg, mode_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [PW-1:0]  tstart_reg, tstart_next;
    logic [PW-1:0]  wlen_reg, wlen_next;
    logic [1:0]     pend_reg, pend_next;
    logic [7:0]     chars_reg [KEYWORD_MAX_CHARS];
    logic [7:0]     chars_next [KEYWORD_MAX_CHARS];

    elx_pkg::token_t [elx_pkg::MAX_TOKENS-1:0] tok;
    logic [1:0]     cnt;
    logic           close_ok;
    logic           fire;
    logic [7:0]     c;
    logic           c_space, c_alpha, c_digit, c_single, c_pend;
    logic [4:0]     single_kind;
    logic [1:0]     pend_code;

    function automatic logic [4:0] word_kind(input logic [7:0] chars [KEYWORD_MAX_CHARS],
                                             input logic [PW-1:0] len);
        logic [4:0] kind;
        logic       hit;
        kind = elx_pkg::KIND_IDENT;
        for (int k = elx_pkg::KW_COUNT - 1; k >= 0; k--) begin
            hit = (len == PW'(elx_pkg::KW_LEN[k]));
            for (int i = 0; i < 9; i++) begin
                if (i < elx_pkg::KW_LEN[k]) begin
                    hit = hit && (chars[i] ==
                          elx_pkg::KW_TEXT[k][(elx_pkg::KW_LEN[k] - 1 - i) * 8 +: 8]);
                end
            end
            if (hit) begin
                kind = elx_pkg::KIND_KEYWORD0 + 5'(k);
            end
        end
        return kind;
    endfunction

    function automatic elx_pkg::token_t make_tok(input logic [4:0] kind,
                                                 input logic [PW-1:0] start,
                                                 input logic [PW-1:0] len);
        elx_pkg::token_t t;
        t.kind   = kind;
        t.start  = 16'(start);
        t.length = 16'(len);
        return t;
    endfunction

    assign s_tready = !queue_full;
    assign fire     = s_tvalid && s_tready;
    assign c        = s_tdata;

    // Character classes.
    always_comb begin
        c_space = (c == elx_pkg::CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
        c_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        c_digit = (c >= "0" && c <= "9");
        c_single    = 1'b1;
        single_kind = elx_pkg::KIND_PLUS;
        unique case (c)
            elx_pkg::CH_PLUS:   single_kind = elx_pkg::KIND_PLUS;
            elx_pkg::CH_MINUS:  single_kind = elx_pkg::KIND_MINUS;
            elx_pkg::CH_STAR:   single_kind = elx_pkg::KIND_STAR;
            elx_pkg::CH_SLASH:  single_kind = elx_pkg::KIND_SLASH;
            elx_pkg::CH_LPAREN: single_kind = elx_pkg::KIND_LPAREN;
            elx_pkg::CH_RPAREN: single_kind = elx_pkg::KIND_RPAREN;
            default:            c_single    = 1'b0;
        endcase
        c_pend    = 1'b1;
        pend_code = elx_pkg::PEND_LT;
        unique case (c)
            elx_pkg::CH_LT:   pend_code = elx_pkg::PEND_LT;
            elx_pkg::CH_GT:   pend_code = elx_pkg::PEND_GT;
            elx_pkg::CH_EQ:   pend_code = elx_pkg::PEND_EQ;
            elx_pkg::CH_BANG: pend_code = elx_pkg::PEND_BANG;
            default:          c_pend    = 1'b0;
        endcase
    end

    always_comb begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        tstart_next = tstart_reg;
        wlen_next   = wlen_reg;
        pend_next   = pend_reg;
        chars_next  = chars_reg;
        tok         = '0;
        cnt         = 2'd0;
        close_ok    = 1'b1;

        // Character part of the item.
        if (fire && s_tuser && mode_reg != MODE_DISCARD) begin
            if (mode_reg == MODE_PENDING && c == elx_pkg::CH_EQ) begin
                tok[cnt]  = make_tok(elx_pkg::KIND_LE + 5'(pend_reg), tstart_reg, PW'(2));
                cnt       = cnt + 2'd1;
                mode_next = MODE_IDLE;
            end else if ((mode_reg == MODE_WORD && (c_alpha || c_digit ||
                          c == elx_pkg::CH_UNDER)) ||
                         (mode_reg == MODE_NUMBER && c_digit)) begin
                if (wlen_reg < PW'(KEYWORD_MAX_CHARS)) begin
                    chars_next[wlen_reg[KI-1:0]] = c;
                end
                if (wlen_reg != '1) begin
                    wlen_next = wlen_reg + 1'b1;
                end
            end else begin
                unique case (mode_reg)
                    MODE_WORD: begin
                        tok[cnt] = make_tok(word_kind(chars_reg, wlen_reg), tstart_reg,
                                            wlen_reg);
                        cnt      = cnt + 2'd1;
                    end
                    MODE_NUMBER: begin
                        tok[cnt] = make_tok(elx_pkg::KIND_NUMBER, tstart_reg, wlen_reg);
                        cnt      = cnt + 2'd1;
                    end
                    MODE_PENDING: begin
                        if (pend_reg == elx_pkg::PEND_LT) begin
                            tok[cnt] = make_tok(elx_pkg::KIND_LT, tstart_reg, PW'(1));
                        end else if (pend_reg == elx_pkg::PEND_GT) begin
                            tok[cnt] = make_tok(elx_pkg::KIND_GT, tstart_reg, PW'(1));
                        end else begin
                            tok[cnt] = make_tok(elx_pkg::KIND_ERROR, tstart_reg, PW'(1));
                            close_ok = 1'b0;
                        end
                        cnt = cnt + 2'd1;
                    end
                    default: ;
                endcase
                if (!close_ok) begin
                    mode_next = MODE_DISCARD;
                end else begin
                    mode_next = MODE_IDLE;
                    if (c_space) begin
                        mode_next = MODE_IDLE;
                    end else if (c_pend) begin
                        mode_next   = MODE_PENDING;
                        pend_next   = pend_code;
                        tstart_next = pos_reg;
                    end else if (c_single) begin
                        tok[cnt] = make_tok(single_kind, pos_reg, PW'(1));
                        cnt      = cnt + 2'd1;
                    end else if (c_alpha || c_digit) begin
                        mode_next     = c_alpha ? MODE_WORD : MODE_NUMBER;
                        tstart_next   = pos_reg;
                        chars_next[0] = c;
                        wlen_next     = PW'(1);
                    end else begin
                        tok[cnt]  = make_tok(elx_pkg::KIND_ERROR, pos_reg, PW'(1));
                        cnt       = cnt + 2'd1;
                        mode_next = MODE_DISCARD;
                    end
                end
            end
            if (pos_reg != '1) begin
                pos_next = pos_reg + 1'b1;
            end
        end

        // End of stream: close what is open, then eof unless an error arose, then back to the start.
        if (fire && s_tlast) begin
            if (mode_next != MODE_DISCARD) begin
                close_ok = 1'b1;
                unique case (mode_next)
                    MODE_WORD: begin
                        tok[cnt] = make_tok(word_kind(chars_next, wlen_next), tstart_next,
                                            wlen_next);
                        cnt      = cnt + 2'd1;
                    end
                    MODE_NUMBER: begin
                        tok[cnt] = make_tok(elx_pkg::KIND_NUMBER, tstart_next, wlen_next);
                        cnt      = cnt + 2'd1;
                    end
                    MODE_PENDING: begin
                        if (pend_next == elx_pkg::PEND_LT) begin
                            tok[cnt] = make_tok(elx_pkg::KIND_LT, tstart_next, PW'(1));
                        end else if (pend_next == elx_pkg::PEND_GT) begin
                            tok[cnt] = make_tok(elx_pkg::KIND_GT, tstart_next, PW'(1));
                        end else begin
                            tok[cnt] = make_tok(elx_pkg::KIND_ERROR, tstart_next, PW'(1));
                            close_ok = 1'b0;
                        end
                        cnt = cnt + 2'd1;
                    end
                    default: ;
                endcase
                if (close_ok) begin
                    tok[cnt] = make_tok(elx_pkg::KIND_EOF, pos_next, PW'(0));
                    cnt      = cnt + 2'd1;
                end
            end
            mode_next   = MODE_IDLE;
            pos_next    = '0;
            tstart_next = '0;
            wlen_next   = '0;
            pend_next   = '0;
        end
    end

    assign push              = fire && (cnt != 2'd0);
    assign push_bundle.count = cnt;
    assign push_bundle.tok   = tok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            tstart_reg <= '0;
            wlen_reg   <= '0;
            pend_reg   <= '0;
        end else begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            tstart_reg <= tstart_next;
            wlen_reg   <= wlen_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        chars_reg <= chars_next;
    end

endmodule

`default_nettype wire

// ----- design/elx_queue.sv -----
// Short queue of token bundles between the front and back parts.
`default_nettype none

module elx_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire elx_pkg::bundle_t  push_bundle,
    output logic                   full,
    input  wire logic              pop,
    output elx_pkg::bundle_t       pop_bundle,
    output logic                   empty
);

    localparam int DEPTH = elx_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    elx_pkg::bundle_t entry_reg [DEPTH];
    logic [AW-1:0]    wr_reg, wr_next;
    logic [AW-1:0]    rd_reg, rd_next;
    logic [AW:0]      count_reg, count_next;

    assign full       = (count_reg == (AW+1)'(DEPTH));
    assign empty      = (count_reg == '0);
    assign pop_bundle = entry_reg[rd_reg];

    always_comb begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push) begin
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_reg] <= push_bundle;
        end
    end

endmodule

`default_nettype wire

// ----- design/elx_back.sv -----
// Back part: holds one bundle and hands its tokens out one per cycle while m_tready is high.
`default_nettype none

module elx_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire elx_pkg::bundle_t  pop_bundle,
    input  wire logic              empty,
    output logic                   pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [39:0]            m_tdata,
    output logic                   m_tlast
);

    elx_pkg::bundle_t cur_reg, cur_next;
    logic             valid_reg, valid_next;
    logic [1:0]       idx_reg, idx_next;
    logic             last;
    logic             out_fire;
    logic             advance;
    elx_pkg::token_t  tok;

    assign last     = (idx_reg == cur_reg.count - 2'd1);
    assign out_fire = valid_reg && m_tready;
    assign advance  = !valid_reg || (out_fire && last);
    assign pop      = advance && !empty;
    assign tok      = cur_reg.tok[idx_reg];

    assign m_tvalid = valid_reg;
    assign m_tlast  = last;
    assign m_tdata  = {3'b000, tok.length, tok.start, tok.kind};

    always_comb begin
        cur_next   = cur_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (advance) begin
            cur_next   = pop_bundle;
            valid_next = !empty;
            idx_next   = 2'd0;
        end else if (out_fire) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

endmodule

`default_nettype wire

// ----- design/expression_lexer_top.sv -----
// Top level of the expression lexer: front part, bundle queue and back part.
// The bundle of an item is written into the queue at the edge that accepts the item, and then
// into the back part's registers, before its first token is presented on the m_ side.
// Throughput: one character item per cycle while the four-bundle queue has room; the back
// part delivers one token per cycle while m_tready is high, so items that cause two or three
// tokens drain slower. Reset: synchronous, active-low aresetn clears the scan state, the queue
// and the output stage; no clearing pass follows, so items are taken once reset is released.
`default_nettype none

module expression_lexer_top #(
    parameter int POSITION_WIDTH    = elx_pkg::POSITION_WIDTH_DEF,
    parameter int KEYWORD_MAX_CHARS = elx_pkg::KEYWORD_MAX_CHARS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Character items.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tuser,   // [0] has_char
    input  wire logic        s_tlast,   // end_of_stream
    // Token items.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [4:0] token_kind, [20:5] start_offset,
                                        // [36:21] token_length, [39:37] zero
    output logic             m_tlast    // last_of_run
);

    // The front part runs the scanner itself. Every accepted item moves the scan state
    // at once, and the tokens that the item completes leave as one bundle of up to three.
    // The front stalls only when the queue is full.
    logic             push;
    logic             full;
    logic             pop;
    logic             empty;
    elx_pkg::bundle_t push_bundle;
    elx_pkg::bundle_t pop_bundle;

    elx_front #(
        .POSITION_WIDTH    (POSITION_WIDTH),
        .KEYWORD_MAX_CHARS (KEYWORD_MAX_CHARS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .push        (push),
        .push_bundle (push_bundle),
        .queue_full  (full)
    );

    // The queue decouples the scanner from the consumer of tokens, so a stalled
    // m_tready side does not stop characters until the queue fills up.
    elx_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_bundle (push_bundle),
        .full        (full),
        .pop         (pop),
        .pop_bundle  (pop_bundle),
        .empty       (empty)
    );

    // The back part holds one bundle in registers and presents its tokens in order.
    // The last token of a bundle carries m_tlast, and the next bundle is loaded in the
    // same cycle that this token is taken, so tokens flow without gaps while the queue is not empty.
    elx_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_bundle (pop_bundle),
        .empty      (empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
